### sv/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

    // Default and largest supported coordinate width
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COORD_WIDTH_MAX = 32;

    // Four orientation tests, two products each
    localparam int NUM_ORIENT = 4;
    localparam int NUM_PROD   = 2 * NUM_ORIENT;

    // Coordinate differences formed in the first stage
    localparam int DIFF_BA_X  = 0;
    localparam int DIFF_BA_Y  = 1;
    localparam int DIFF_CA_X  = 2;
    localparam int DIFF_CA_Y  = 3;
    localparam int DIFF_DA_X  = 4;
    localparam int DIFF_DA_Y  = 5;
    localparam int DIFF_DC_X  = 6;
    localparam int DIFF_DC_Y  = 7;
    localparam int DIFF_AC_X  = 8;
    localparam int DIFF_AC_Y  = 9;
    localparam int DIFF_BC_X  = 10;
    localparam int DIFF_BC_Y  = 11;
    localparam int DIFF_COUNT = 12;

    // Endpoints after per-segment ordering
    localparam int PT_LO1   = 0;
    localparam int PT_HI1   = 1;
    localparam int PT_LO2   = 2;
    localparam int PT_HI2   = 3;
    localparam int PT_COUNT = 4;

    // Orientation signs: pos set for a positive cross product, zero for zero
    typedef struct packed {
        logic [NUM_ORIENT-1:0] pos;
        logic [NUM_ORIENT-1:0] zero;
    } sit_orient_t;

    // Point order: by x first, then by y
    function automatic logic pt_less(
        input logic signed [COORD_WIDTH_MAX-1:0] px,
        input logic signed [COORD_WIDTH_MAX-1:0] py,
        input logic signed [COORD_WIDTH_MAX-1:0] qx,
        input logic signed [COORD_WIDTH_MAX-1:0] qy
    );
        return (px < qx) || ((px == qx) && (py < qy));
    endfunction

endpackage

### sv/sit_prep.sv
`timescale 1ns / 1ps

module sit_prep #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] d_x,
    input  logic signed [COORD_WIDTH-1:0] d_y,
    output logic                          out_valid,
    output logic signed [COORD_WIDTH:0]   diff [sit_pkg::DIFF_COUNT],
    output logic signed [COORD_WIDTH-1:0] ord_x [sit_pkg::PT_COUNT],
    output logic signed [COORD_WIDTH-1:0] ord_y [sit_pkg::PT_COUNT]
);
    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic                          valid_reg;
    logic signed [DW-1:0]          diff_reg  [DIFF_COUNT];
    logic signed [DW-1:0]          diff_next [DIFF_COUNT];
    logic signed [COORD_WIDTH-1:0] ord_x_reg  [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] ord_y_reg  [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] ord_x_next [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] ord_y_next [PT_COUNT];
    logic                          swap_ab;
    logic                          swap_cd;

    // Sign-extend by one bit, then subtract: the difference is exact
    function automatic logic signed [DW-1:0] sub_ext(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        return {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
    endfunction

    always_comb
    begin
        diff_next[DIFF_BA_X] = sub_ext(b_x, a_x);
        diff_next[DIFF_BA_Y] = sub_ext(b_y, a_y);
        diff_next[DIFF_CA_X] = sub_ext(c_x, a_x);
        diff_next[DIFF_CA_Y] = sub_ext(c_y, a_y);
        diff_next[DIFF_DA_X] = sub_ext(d_x, a_x);
        diff_next[DIFF_DA_Y] = sub_ext(d_y, a_y);
        diff_next[DIFF_DC_X] = sub_ext(d_x, c_x);
        diff_next[DIFF_DC_Y] = sub_ext(d_y, c_y);
        diff_next[DIFF_AC_X] = sub_ext(a_x, c_x);
        diff_next[DIFF_AC_Y] = sub_ext(a_y, c_y);
        diff_next[DIFF_BC_X] = sub_ext(b_x, c_x);
        diff_next[DIFF_BC_Y] = sub_ext(b_y, c_y);
    end

    // Order each segment's endpoints so the low one comes first
    assign swap_ab = pt_less(COORD_WIDTH_MAX'(b_x), COORD_WIDTH_MAX'(b_y),
                             COORD_WIDTH_MAX'(a_x), COORD_WIDTH_MAX'(a_y));
    assign swap_cd = pt_less(COORD_WIDTH_MAX'(d_x), COORD_WIDTH_MAX'(d_y),
                             COORD_WIDTH_MAX'(c_x), COORD_WIDTH_MAX'(c_y));

    always_comb
    begin
        ord_x_next[PT_LO1] = swap_ab ? b_x : a_x;
        ord_y_next[PT_LO1] = swap_ab ? b_y : a_y;
        ord_x_next[PT_HI1] = swap_ab ? a_x : b_x;
        ord_y_next[PT_HI1] = swap_ab ? a_y : b_y;
        ord_x_next[PT_LO2] = swap_cd ? d_x : c_x;
        ord_y_next[PT_LO2] = swap_cd ? d_y : c_y;
        ord_x_next[PT_HI2] = swap_cd ? c_x : d_x;
        ord_y_next[PT_HI2] = swap_cd ? c_y : d_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        ord_x_reg <= ord_x_next;
        ord_y_reg <= ord_y_next;
    end

    assign out_valid = valid_reg;
    assign diff      = diff_reg;
    assign ord_x     = ord_x_reg;
    assign ord_y     = ord_y_reg;

endmodule

### sv/sit_cross.sv
`timescale 1ns / 1ps

module sit_cross #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [COORD_WIDTH:0] diff [sit_pkg::DIFF_COUNT],
    output logic                        out_valid,
    output sit_pkg::sit_orient_t        orient
);
    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic                 prod_valid_reg;
    logic                 sign_valid_reg;
    logic signed [PW-1:0] prod_reg  [NUM_PROD];
    logic signed [PW-1:0] prod_next [NUM_PROD];
    sit_orient_t          orient_reg;
    sit_orient_t          orient_next;

    // Each orientation is ux*vy - uy*vx; hold both products apart
    always_comb
    begin
        prod_next[0] = PW'(diff[DIFF_BA_X]) * PW'(diff[DIFF_CA_Y]);
        prod_next[1] = PW'(diff[DIFF_BA_Y]) * PW'(diff[DIFF_CA_X]);
        prod_next[2] = PW'(diff[DIFF_BA_X]) * PW'(diff[DIFF_DA_Y]);
        prod_next[3] = PW'(diff[DIFF_BA_Y]) * PW'(diff[DIFF_DA_X]);
        prod_next[4] = PW'(diff[DIFF_DC_X]) * PW'(diff[DIFF_AC_Y]);
        prod_next[5] = PW'(diff[DIFF_DC_Y]) * PW'(diff[DIFF_AC_X]);
        prod_next[6] = PW'(diff[DIFF_DC_X]) * PW'(diff[DIFF_BC_Y]);
        prod_next[7] = PW'(diff[DIFF_DC_Y]) * PW'(diff[DIFF_BC_X]);
    end

    // Sign of the cross product from a signed compare of the two products per orientation
    always_comb
    begin
        for (int k = 0; k < NUM_ORIENT; k++)
        begin
            orient_next.pos[k]  = prod_reg[2*k] > prod_reg[2*k+1];
            orient_next.zero[k] = prod_reg[2*k] == prod_reg[2*k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sign_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            sign_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        orient_reg <= orient_next;
    end

    assign out_valid = sign_valid_reg;
    assign orient    = orient_reg;

endmodule

### sv/sit_decide.sv
`timescale 1ns / 1ps

module sit_decide #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_WIDTH-1:0] ord_x [sit_pkg::PT_COUNT],
    input  logic signed [COORD_WIDTH-1:0] ord_y [sit_pkg::PT_COUNT],
    input  logic                          orient_valid,
    input  sit_pkg::sit_orient_t          orient,
    output logic                          done,
    output logic                          intersects
);
    import sit_pkg::*;

    logic overlap_next;
    logic overlap_s2_reg;
    logic overlap_s3_reg;
    logic ab_zero;
    logic cd_zero;
    logic ab_straddle;
    logic cd_straddle;
    logic result_next;
    logic done_reg;
    logic intersects_reg;

    // Extents overlap unless one segment ends before the other begins
    assign overlap_next = !(
        pt_less(COORD_WIDTH_MAX'(ord_x[PT_HI1]), COORD_WIDTH_MAX'(ord_y[PT_HI1]),
                COORD_WIDTH_MAX'(ord_x[PT_LO2]), COORD_WIDTH_MAX'(ord_y[PT_LO2])) ||
        pt_less(COORD_WIDTH_MAX'(ord_x[PT_HI2]), COORD_WIDTH_MAX'(ord_y[PT_HI2]),
                COORD_WIDTH_MAX'(ord_x[PT_LO1]), COORD_WIDTH_MAX'(ord_y[PT_LO1])));

    // A sign product is zero when either sign is zero, negative when they differ
    assign ab_zero     = orient.zero[0] | orient.zero[1];
    assign cd_zero     = orient.zero[2] | orient.zero[3];
    assign ab_straddle = ab_zero | (orient.pos[0] ^ orient.pos[1]);
    assign cd_straddle = cd_zero | (orient.pos[2] ^ orient.pos[3]);

    // A zero sign on both sides (as for collinear, horizontal and vertical included) falls back to extents
    assign result_next = (ab_zero && cd_zero) ? overlap_s3_reg
                                              : (ab_straddle && cd_straddle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= orient_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        overlap_s2_reg <= overlap_next;
        overlap_s3_reg <= overlap_s2_reg;
        intersects_reg <= result_next;
    end

    assign done       = done_reg;
    assign intersects = intersects_reg;

endmodule

### sv/segment_intersection_test.sv
`timescale 1ns / 1ps
// Result: the strobe (done) marks the result of an accepted item once the item
//   has passed every pipeline stage.
// Throughput: one item per cycle; busy is held low, the four-stage pipeline
//   (differences, products, sign compares, decision) always takes a new item.
// Reset: rst_n clears the valid bits of every stage asynchronously; no result
//   is shown until an item is accepted. The receiver cannot stall the block.

module segment_intersection_test #(
    parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] d_x,
    input  logic signed [COORD_WIDTH-1:0] d_y,
    output logic                          done,
    output logic                          intersects
);
    import sit_pkg::*;

    // Stage 1 -> 2: exact coordinate differences and ordered endpoints
    logic                          s1_valid;
    logic signed [COORD_WIDTH:0]   s1_diff  [DIFF_COUNT];
    logic signed [COORD_WIDTH-1:0] s1_ord_x [PT_COUNT];
    logic signed [COORD_WIDTH-1:0] s1_ord_y [PT_COUNT];

    // Stage 3 -> 4: orientation signs of C, D about AB and of A, B about CD
    logic                          s3_valid;
    sit_orient_t                   s3_orient;

    logic                          accept;

    // Nothing downstream can hold the pipeline, so take an item every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    sit_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .d_x       (d_x),
        .d_y       (d_y),
        .out_valid (s1_valid),
        .diff      (s1_diff),
        .ord_x     (s1_ord_x),
        .ord_y     (s1_ord_y)
    );

    // Products are registered, then compared pairwise for the sign
    sit_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .diff      (s1_diff),
        .out_valid (s3_valid),
        .orient    (s3_orient)
    );

    // Extent overlap travels alongside the products and meets the signs here
    sit_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .ord_x        (s1_ord_x),
        .ord_y        (s1_ord_y),
        .orient_valid (s3_valid),
        .orient       (s3_orient),
        .done         (done),
        .intersects   (intersects)
    );

`ifndef SYNTH
    // Every accepted item yields exactly one result strobe
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept && rst_n, 4))
        else $error("result strobe does not match accepted items");

    // Segments that share their first endpoints always meet
    a_shared_first: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept && rst_n && a_x == c_x && a_y == c_y, 4)) |-> intersects)
        else $error("shared first endpoint reported as no intersection");

    // Segments that share their second endpoints always meet
    a_shared_second: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(accept && rst_n && b_x == d_x && b_y == d_y, 4)) |-> intersects)
        else $error("shared second endpoint reported as no intersection");
`endif

endmodule
